@@ src/bsrm_pkg.sv @@
// Shared types and constants for the backing store region map.
package bsrm_pkg;

    localparam int STORE_W    = 4;
    localparam int PAGE_W     = 20;
    localparam int SIZE_W     = 21;
    localparam int PID_W      = 8;
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;

    typedef enum logic [1:0] {
        FN_FIND_FREE = 2'd0,
        FN_FREE      = 2'd1,
        FN_MAP       = 2'd2,
        FN_LOOKUP    = 2'd3
    } t_func;

    typedef struct packed {
        t_func               func;
        logic [STORE_W-1:0]  store_id;
        logic [PID_W-1:0]    pid;
        logic [PAGE_W-1:0]   base_page;
        logic [PAGE_W-1:0]   page_count;
        logic [ADDR_W-1:0]   vaddr;
    } t_in_item;

    typedef struct packed {
        logic                status;
        logic [STORE_W-1:0]  store_out;
        logic [PAGE_W-1:0]   page_offset;
    } t_out_item;

    // Request plus partial answer, handed from cell to cell.
    typedef struct packed {
        logic                valid;
        t_func               func;
        logic [STORE_W-1:0]  store_id;
        logic [PID_W-1:0]    pid;
        logic [PAGE_W-1:0]   base_page;
        logic [PAGE_W-1:0]   page_count;
        logic [PAGE_W-1:0]   vpn;
        logic                map_ok;
        logic                found;
        logic [STORE_W-1:0]  store_out;
        logic [PAGE_W-1:0]   page_offset;
    } t_tok;

endpackage

@@ src/backing_store_region_map.sv @@
// Top level of the backing store region map: a chain of entry cells and the result register.
//
// The table is a row of NUM_STORES cells, one entry per cell, all taken out of reset as
// unmapped with a page count of DEFAULT_PAGES. An accepted request becomes a token that
// walks the row one cell per clock while it is not held, lowest index first; each cell
// checks its own entry, updates it on a free or map addressed to it, and claims the token
// for find free or lookup when no lower cell has already done so. The token is registered
// in each cell and then in the result register, which drives the output; a new request is
// taken in the cycle after the token leaves the last cell, so the block does not take a new
// request before the last one has left the row. One request is in the row at a time, so
// every request sees the table as the previous one left it. The result register decouples
// the two sides: the next request is taken while a finished result still waits for
// its transfer, and the token only holds in the last cell if that result has not yet been
// taken. Find free reports the lowest unmapped index without reserving it; map with an
// out-of-range store or process, free of an unmapped or out-of-range entry, a full table
// and a lookup miss all answer with status set and zero store and offset.
module backing_store_region_map
    import bsrm_pkg::*;
#(
    parameter int NUM_STORES    = 8,
    parameter int DEFAULT_PAGES = 256,
    parameter int MAX_PROCS     = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    t_tok       w_tok [NUM_STORES+1];
    t_tok       w_head;
    logic       w_accept;
    logic       w_advance;
    logic       w_last_hold;
    logic       r_busy;
    logic       r_out_valid;
    t_out_item  r_out;

    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && o_in_ready;

    // Result register is free when empty or when its result transfers this cycle.
    assign w_advance   = !r_out_valid || i_out_ready;
    assign w_last_hold = w_tok[NUM_STORES].valid && !w_advance;

    // Build the token that enters the first cell.
    always_comb begin
        w_head.valid       = w_accept;
        w_head.func        = i_in.func;
        w_head.store_id    = i_in.store_id;
        w_head.pid         = i_in.pid;
        w_head.base_page   = i_in.base_page;
        w_head.page_count  = i_in.page_count;
        w_head.vpn         = i_in.vaddr[PAGE_SHIFT +: PAGE_W];
        w_head.map_ok      = ({1'b0, i_in.pid} < (PID_W+1)'(MAX_PROCS));
        w_head.found       = 1'b0;
        w_head.store_out   = '0;
        w_head.page_offset = '0;
    end

    assign w_tok[0] = w_head;

    // Only the last cell can hold; earlier cells are empty while it does.
    genvar g;
    generate
        for (g = 0; g < NUM_STORES; g++) begin : g_cell
            bsrm_cell #(
                .IDX           (g),
                .DEFAULT_PAGES (DEFAULT_PAGES)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_hold  ((g == NUM_STORES - 1) ? w_last_hold : 1'b0),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    // Busy from the input transfer until the token drops into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_tok[NUM_STORES].valid && w_advance) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_tok[NUM_STORES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_tok[NUM_STORES].valid) begin
            r_out.status      <= !w_tok[NUM_STORES].found;
            r_out.store_out   <= w_tok[NUM_STORES].store_out;
            r_out.page_offset <= w_tok[NUM_STORES].page_offset;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ src/bsrm_cell.sv @@
// One table entry plus the token register that feeds the next cell.
module bsrm_cell
    import bsrm_pkg::*;
#(
    parameter int IDX           = 0,
    parameter int DEFAULT_PAGES = 256
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_hold,
    input  t_tok  i_tok,
    output t_tok  o_tok
);

    logic               r_mapped;
    logic [PID_W-1:0]   r_owner;
    logic [PAGE_W-1:0]  r_first;
    logic [SIZE_W-1:0]  r_size;
    t_tok               r_tok;

    logic               n_mapped;
    logic [PID_W-1:0]   n_owner;
    logic [PAGE_W-1:0]  n_first;
    logic [SIZE_W-1:0]  n_size;
    t_tok               n_tok;

    logic               w_sel;
    logic               w_hit;
    logic [SIZE_W:0]    w_end;

    assign w_sel = (i_tok.store_id == STORE_W'(IDX));
    assign w_end = {2'b00, r_first} + {1'b0, r_size};
    assign w_hit = r_mapped && (r_owner == i_tok.pid) && (r_first <= i_tok.vpn)
                   && (w_end > {2'b00, i_tok.vpn});

    always_comb begin
        n_tok    = i_tok;
        n_mapped = r_mapped;
        n_owner  = r_owner;
        n_first  = r_first;
        n_size   = r_size;
        if (i_tok.valid) begin
            case (i_tok.func)
                FN_FIND_FREE: begin
                    if (!i_tok.found && !r_mapped) begin
                        n_tok.found     = 1'b1;
                        n_tok.store_out = STORE_W'(IDX);
                    end
                end
                FN_FREE: begin
                    if (w_sel && r_mapped) begin
                        n_tok.found = 1'b1;
                        n_mapped    = 1'b0;
                        n_owner     = '0;
                        n_first     = '0;
                        n_size      = SIZE_W'(DEFAULT_PAGES);
                    end
                end
                FN_MAP: begin
                    if (w_sel && i_tok.map_ok) begin
                        n_tok.found = 1'b1;
                        n_mapped    = 1'b1;
                        n_owner     = i_tok.pid;
                        n_first     = i_tok.base_page;
                        n_size      = {1'b0, i_tok.page_count};
                    end
                end
                FN_LOOKUP: begin
                    if (!i_tok.found && w_hit) begin
                        n_tok.found       = 1'b1;
                        n_tok.store_out   = STORE_W'(IDX);
                        n_tok.page_offset = i_tok.vpn - r_first;
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapped <= 1'b0;
            r_owner  <= '0;
            r_first  <= '0;
            r_size   <= SIZE_W'(DEFAULT_PAGES);
        end else if (!i_hold) begin
            r_mapped <= n_mapped;
            r_owner  <= n_owner;
            r_first  <= n_first;
            r_size   <= n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (!i_hold) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
